// ===== design/assert_macros.svh =====
// Assertion macros for the checker file of the project.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define OWS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property, also checked while reset is asserted.
`define OWS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/ows_pkg.sv =====
// Types and constants shared by the 1-Wire ROM search engine.
// No dependencies.
package ows_pkg;

    localparam int POS_W      = 7;
    localparam int ROM_W      = 64;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 80;

    localparam logic [POS_W-1:0] ROM_BITS     = 7'd64;
    localparam logic [POS_W-1:0] FAMILY_LIMIT = 7'd9;

    typedef enum logic [1:0] {
        OP_RESTART = 2'd0,
        OP_TARGET  = 2'd1,
        OP_BEGIN   = 2'd2,
        OP_BIT     = 2'd3
    } op_t;

    // Read bit pair class: bits differ, both zero (discrepancy), both one (no device)
    typedef enum logic [1:0] {
        PAIR_DIFFER   = 2'd0,
        PAIR_BOTH_ZERO = 2'd1,
        PAIR_BOTH_ONE = 2'd2
    } pair_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] family_byte;
        logic       reset_failed;
        logic       id_bit;
        pair_t      pair;
    } cmd_t;

    typedef struct packed {
        logic              send_search_cmd;
        logic              write_valid;
        logic              write_dir;
        logic              pass_done;
        logic              found;
        logic [ROM_W-1:0]  rom_id;
        logic [POS_W-1:0]  family_discrepancy;
    } result_t;

endpackage

// ===== design/ows_front.sv =====
// Front stage: accepts input items, decodes action and bit pair class.
// Depends on ows_pkg.
module ows_front
    import ows_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] action,
    input  logic [7:0] family_byte,
    input  logic       reset_failed,
    input  logic       id_bit,
    input  logic       comp_bit,
    output logic       push_valid,
    input  logic       push_ready,
    output cmd_t       push_cmd
);

    logic  valid_reg;
    logic  valid_next;
    cmd_t  cmd_reg;
    cmd_t  cmd_next;
    pair_t pair;

    assign in_ready = !valid_reg || push_ready;

    always_comb
    begin
        if (id_bit != comp_bit)
            pair = PAIR_DIFFER;
        else if (id_bit)
            pair = PAIR_BOTH_ONE;
        else
            pair = PAIR_BOTH_ZERO;

        cmd_next.op           = op_t'(action);
        cmd_next.family_byte  = family_byte;
        cmd_next.reset_failed = reset_failed;
        cmd_next.id_bit       = id_bit;
        cmd_next.pair         = pair;

        valid_next = valid_reg;
        if (in_ready)
            valid_next = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            cmd_reg <= cmd_next;
    end

    assign push_valid = valid_reg;
    assign push_cmd   = cmd_reg;

endmodule

// ===== design/ows_fifo.sv =====
// Short command queue between the front and back stages.
// Depends on ows_pkg.
module ows_fifo
    import ows_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ===== design/ows_back.sv =====
// Back stage: search state, direction choice per bit pair, result register.
// Depends on ows_pkg.
module ows_back
    import ows_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    output logic    cmd_ready,
    input  cmd_t    cmd,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    logic [ROM_W-1:0] rom_reg;
    logic [ROM_W-1:0] rom_next;
    logic [POS_W-1:0] last_disc_reg;
    logic [POS_W-1:0] last_disc_next;
    logic [POS_W-1:0] fam_disc_reg;
    logic [POS_W-1:0] fam_disc_next;
    logic             last_dev_reg;
    logic             last_dev_next;
    logic [POS_W-1:0] bit_pos_reg;
    logic [POS_W-1:0] bit_pos_next;
    logic [POS_W-1:0] last_zero_reg;
    logic [POS_W-1:0] last_zero_next;
    logic             active_reg;
    logic             active_next;
    logic             res_valid_reg;
    logic             res_valid_next;
    result_t          res_reg;
    result_t          res_next;

    logic             pop;
    logic [5:0]       idx;
    logic [POS_W-1:0] pos_inc;
    logic             dir;

    assign cmd_ready = !res_valid_reg || res_ready;
    assign pop       = cmd_valid && cmd_ready;
    assign idx       = 6'(bit_pos_reg - 7'd1);
    assign pos_inc   = bit_pos_reg + 7'd1;

    always_comb
    begin
        if (cmd.pair == PAIR_DIFFER)
            dir = cmd.id_bit;
        else if (bit_pos_reg < last_disc_reg)
            dir = rom_reg[idx];
        else
            dir = (bit_pos_reg == last_disc_reg);
    end

    always_comb
    begin
        rom_next       = rom_reg;
        last_disc_next = last_disc_reg;
        fam_disc_next  = fam_disc_reg;
        last_dev_next  = last_dev_reg;
        bit_pos_next   = bit_pos_reg;
        last_zero_next = last_zero_reg;
        active_next    = active_reg;
        res_next       = '0;

        if (pop)
        begin
            unique case (cmd.op) inside
                OP_RESTART, OP_TARGET:
                begin
                    rom_next       = '0;
                    last_disc_next = '0;
                    fam_disc_next  = '0;
                    last_dev_next  = 1'b0;
                    active_next    = 1'b0;
                    if (cmd.op == OP_TARGET)
                    begin
                        rom_next[7:0]  = cmd.family_byte;
                        last_disc_next = ROM_BITS;
                    end
                end
                OP_BEGIN:
                begin
                    if (last_dev_reg || cmd.reset_failed)
                    begin
                        last_disc_next     = '0;
                        fam_disc_next      = '0;
                        last_dev_next      = 1'b0;
                        active_next        = 1'b0;
                        res_next.pass_done = 1'b1;
                    end
                    else
                    begin
                        res_next.send_search_cmd = 1'b1;
                        active_next              = 1'b1;
                        bit_pos_next             = 7'd1;
                        last_zero_next           = '0;
                    end
                end
                OP_BIT:
                begin
                    if (active_reg && cmd.pair == PAIR_BOTH_ONE)
                    begin
                        last_disc_next     = '0;
                        fam_disc_next      = '0;
                        last_dev_next      = 1'b0;
                        active_next        = 1'b0;
                        res_next.pass_done = 1'b1;
                    end
                    else if (active_reg)
                    begin
                        if (cmd.pair == PAIR_BOTH_ZERO && !dir)
                        begin
                            last_zero_next = bit_pos_reg;
                            if (bit_pos_reg < FAMILY_LIMIT)
                                fam_disc_next = bit_pos_reg;
                        end
                        rom_next[idx]        = dir;
                        res_next.write_valid = 1'b1;
                        res_next.write_dir   = dir;
                        bit_pos_next         = pos_inc;
                        if (pos_inc > ROM_BITS)
                        begin
                            // pass complete: next search restarts from the last zero taken
                            active_next        = 1'b0;
                            res_next.pass_done = 1'b1;
                            last_disc_next     = last_zero_next;
                            if (last_zero_next == '0)
                                last_dev_next = 1'b1;
                            res_next.found = 1'b1;
                            if (rom_next[7:0] == 8'd0)
                            begin
                                last_disc_next = '0;
                                fam_disc_next  = '0;
                                last_dev_next  = 1'b0;
                                res_next.found = 1'b0;
                            end
                        end
                    end
                end
                default:
                begin
                    active_next = active_reg;
                end
            endcase
        end

        res_next.rom_id             = rom_next;
        res_next.family_discrepancy = fam_disc_next;

        res_valid_next = res_valid_reg;
        if (pop)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_reg       <= '0;
            last_disc_reg <= '0;
            fam_disc_reg  <= '0;
            last_dev_reg  <= 1'b0;
            bit_pos_reg   <= 7'd1;
            last_zero_reg <= '0;
            active_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            rom_reg       <= rom_next;
            last_disc_reg <= last_disc_next;
            fam_disc_reg  <= fam_disc_next;
            last_dev_reg  <= last_dev_next;
            bit_pos_reg   <= bit_pos_next;
            last_zero_reg <= last_zero_next;
            active_reg    <= active_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== design/one_wire_rom_search.sv =====
// 1-Wire ROM search engine: input item stream in, one result item per input out.
// Slave channel s_axis carries actions and read bit pairs; master channel m_axis
// carries the command/write/done flags, the ROM image and the family discrepancy.
// Every accepted input item yields exactly one result item, in order.
// Action in s_axis_tuser: restart, target family, begin pass, bit pair. A begin pass
// result flags the search command, or ends with tlast after the last device or a
// failed reset; each bit pair of a pass returns the direction bit to write; the 64th
// bit pair or an all-ones pair ends the pass with tlast, and the result holds the ROM image and the found flag.
// An accepted item passes the front register, a queue entry, then the output register
// loaded by the back stage.
// Throughput: one item per cycle; the back stage updates the search state
// for one item each cycle it can place a result in the output register.
// Reset clears the search state (ROM image zero, bit position one, no pass
// active) and empties the queue and output register.
// When the receiver holds m_axis_tready low the result holds; the queue of
// QUEUE_DEPTH items and the front register fill, then s_axis_tready drops.
// Depends on ows_pkg, ows_front, ows_fifo, ows_back.
module one_wire_rom_search
    import ows_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [7:0] family_byte, [8] reset_failed, [9] id_bit, [10] comp_bit, rest zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] action
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] write_dir, [1] found, [65:2] rom_id, [72:66] family_discrepancy, rest zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // [0] send_search_cmd, [1] write_valid
    output logic [1:0]            m_axis_tuser,
    // pass_done
    output logic                  m_axis_tlast
);

    logic    push_valid;
    logic    push_ready;
    cmd_t    push_cmd;
    logic    pop_valid;
    logic    pop_ready;
    cmd_t    pop_cmd;
    result_t res;

    ows_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .action       (s_axis_tuser),
        .family_byte  (s_axis_tdata[7:0]),
        .reset_failed (s_axis_tdata[8]),
        .id_bit       (s_axis_tdata[9]),
        .comp_bit     (s_axis_tdata[10]),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_cmd     (push_cmd)
    );

    ows_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    ows_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .cmd       (pop_cmd),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {7'd0, res.family_discrepancy, res.rom_id, res.found, res.write_dir};
    assign m_axis_tuser = {res.write_valid, res.send_search_cmd};
    assign m_axis_tlast = res.pass_done;

endmodule

// ===== design/ows_checker.sv =====
// Port-level checks on the result channel of one_wire_rom_search, bound to it.
// Depends on assert_macros.svh and ows_pkg.
`include "assert_macros.svh"

module ows_checker
    import ows_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [1:0]            m_axis_tuser,
    input logic                  m_axis_tlast
);

    `OWS_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |-> !m_axis_tvalid, "result during reset")
    `OWS_ASSERT(a_stall_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")
    `OWS_ASSERT(a_dir_needs_write, clk, rst_n, m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tuser[1], "direction without write")
    `OWS_ASSERT(a_found_needs_done, clk, rst_n, m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tlast, "found without pass end")
    `OWS_ASSERT(a_cmd_alone, clk, rst_n, m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1] && !m_axis_tlast, "search command mixed with bit result")

endmodule

bind one_wire_rom_search ows_checker u_ows_checker (.*);
